[src/cdp_pkg.sv]
// shared types, constants and helpers of the cookie date parser
package cdp_pkg;

	localparam int QueueDepth = 4;

	typedef struct packed {
		logic        command;
		logic [7:0]  char_byte;
		logic [62:0] now_seconds;
	} in_word_t;

	typedef struct packed {
		logic        date_valid;
		logic [37:0] expiry_seconds;
	} out_word_t;

	// one finished value handed from the front to the back
	typedef struct packed {
		logic        ok;
		logic [13:0] year;
		logic [3:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [62:0] now;
	} date_job_t;

	function automatic logic is_delim(input logic [7:0] c);
		return c == 8'h09 || (c >= 8'h20 && c <= 8'h2f) || (c >= 8'h3b && c <= 8'h40) ||
			(c >= 8'h5b && c <= 8'h60) || (c >= 8'h7b && c <= 8'h7e);
	endfunction

	function automatic logic [3:0] month_of(input logic [23:0] p);
		case (p)
			"jan": return 4'd1;
			"feb": return 4'd2;
			"mar": return 4'd3;
			"apr": return 4'd4;
			"may": return 4'd5;
			"jun": return 4'd6;
			"jul": return 4'd7;
			"aug": return 4'd8;
			"sep": return 4'd9;
			"oct": return 4'd10;
			"nov": return 4'd11;
			"dec": return 4'd12;
			default: return 4'd0;
		endcase
	endfunction

endpackage

[src/cdp_front.sv]
// per-byte tokeniser and classifier of the date parts
module cdp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	input  cdp_pkg::in_word_t  word,
	output logic               job_valid,
	output cdp_pkg::date_job_t job
);
	import cdp_pkg::*;

	logic [2:0]  len_q;
	logic        alld_q;
	logic [13:0] num_q;
	logic [23:0] pre_q;
	logic [1:0]  colons_q;
	logic [1:0]  digits_q;
	logic        bad_q;
	logic [6:0]  tf_q [3];
	logic [3:0]  found_q;
	logic [6:0]  clk_q [3];
	logic [6:0]  day_q;
	logic [3:0]  mon_q;
	logic [13:0] year_q;

	logic [7:0] c;
	logic       digit, delim, fin;
	logic [3:0] d, mfound;
	logic       take_time, take_day, take_mon, take_year;
	logic [3:0] found_n;
	logic [6:0] clk_n [3];
	logic [6:0] day_n;
	logic [3:0] mon_n;
	logic [13:0] year_n;

	assign c     = word.char_byte;
	assign digit = c >= 8'h30 && c <= 8'h39;
	assign d     = 4'(c - 8'h30);
	assign delim = is_delim(c);
	assign fin   = valid && (word.command || delim);
	assign mfound = (len_q >= 3'd3) ? month_of(pre_q) : 4'd0;

	// token classification in priority order
	always_comb begin
		take_time = 1'b0; take_day = 1'b0; take_mon = 1'b0; take_year = 1'b0;
		if (len_q != 3'd0) begin
			if (!found_q[0] && !bad_q && colons_q == 2'd2 && digits_q != 2'd0)
				take_time = 1'b1;
			else if (!found_q[1] && alld_q && len_q <= 3'd2)
				take_day = 1'b1;
			else if (!found_q[2] && mfound != 4'd0)
				take_mon = 1'b1;
			else if (!found_q[3] && alld_q && len_q >= 3'd2 && len_q <= 3'd4)
				take_year = 1'b1;
		end
		found_n = found_q | {take_year, take_mon, take_day, take_time};
		for (int i = 0; i < 3; i++) clk_n[i] = take_time ? tf_q[i] : clk_q[i];
		day_n  = take_day ? num_q[6:0] : day_q;
		mon_n  = take_mon ? mfound : mon_q;
		year_n = take_year ? num_q : year_q;
	end

	// hand the collected parts on at the end word
	always_comb begin
		job_valid  = valid && word.command;
		job.ok     = found_n == 4'hf;
		job.year   = year_n;
		job.month  = mon_n;
		job.day    = day_n;
		job.hour   = clk_n[0];
		job.minute = clk_n[1];
		job.second = clk_n[2];
		job.now    = word.now_seconds;
	end

	// token and part state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0; alld_q <= 1'b1; num_q <= '0; pre_q <= '0;
			colons_q <= '0; digits_q <= '0; bad_q <= 1'b0;
			found_q <= '0; day_q <= '0; mon_q <= '0; year_q <= '0;
			for (int i = 0; i < 3; i++) begin tf_q[i] <= '0; clk_q[i] <= '0; end
		end else if (valid) begin
			if (fin) begin
				len_q <= '0; alld_q <= 1'b1; num_q <= '0; pre_q <= '0;
				colons_q <= '0; digits_q <= '0; bad_q <= 1'b0;
				for (int i = 0; i < 3; i++) tf_q[i] <= '0;
				if (word.command) begin
					found_q <= '0; day_q <= '0; mon_q <= '0; year_q <= '0;
					for (int i = 0; i < 3; i++) clk_q[i] <= '0;
				end else begin
					found_q <= found_n; day_q <= day_n; mon_q <= mon_n; year_q <= year_n;
					for (int i = 0; i < 3; i++) clk_q[i] <= clk_n[i];
				end
			end else begin
				if (len_q < 3'd3)
					pre_q[5'(16 - 8 * len_q) +: 8] <= (c >= 8'h41 && c <= 8'h5a) ?
						c + 8'h20 : c;
				if (digit) begin
					if (alld_q && len_q < 3'd4)
						num_q <= 14'(num_q * 14'd10 + 14'(d));
					if (digits_q >= 2'd2) bad_q <= 1'b1;
					else begin
						digits_q <= digits_q + 2'd1;
						if (colons_q <= 2'd2)
							tf_q[colons_q] <= 7'(tf_q[colons_q] * 7'd10 + 7'(d));
					end
				end else begin
					alld_q <= 1'b0;
					if (c == 8'h3a) begin
						if (digits_q == 2'd0 || colons_q >= 2'd2) bad_q <= 1'b1;
						if (colons_q < 2'd3) colons_q <= colons_q + 2'd1;
						digits_q <= '0;
					end else bad_q <= 1'b1;
				end
				if (len_q < 3'd5) len_q <= len_q + 3'd1;
			end
		end
	end

endmodule

[src/cdp_queue.sv]
// short queue between front and back
module cdp_queue #(
	parameter int Depth = cdp_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cdp_pkg::date_job_t wdata,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output cdp_pkg::date_job_t rdata
);
	import cdp_pkg::*;
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	date_job_t       mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign full  = cnt_q == (AW+1)'(Depth);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push && !full)
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (pop && !empty)
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end

endmodule

[src/cdp_back.sv]
// range checks and epoch arithmetic, three stages into an output register
module cdp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_empty,
	input  cdp_pkg::date_job_t  job,
	output logic                job_pop,
	output logic                empty,
	input  logic                pop,
	output cdp_pkg::out_word_t  result
);
	import cdp_pkg::*;

	logic        v_s1, v_s2, v_s3, v_q;
	logic        adv1, adv2, adv3, adv_o;

	// stage 1: year fold, field checks, hundreds of the year, day of year
	logic        ok_s1;
	logic [13:0] yf_s1, y_s1;
	logic [6:0]  yfh_s1, yh_s1;
	logic [3:0]  mon_s1;
	logic [6:0]  day_s1;
	logic [8:0]  doy_s1;
	logic [16:0] tod_s1;
	logic [62:0] now_s1;
	logic [13:0] yf, y;
	logic        ok1;
	logic [8:0]  mstart;
	logic [26:0] yf_mul, y_mul;

	always_comb begin
		if (job.year >= 14'd70 && job.year <= 14'd99) yf = job.year + 14'd1900;
		else if (job.year <= 14'd69) yf = job.year + 14'd2000;
		else yf = job.year;
		y = yf - ((job.month <= 4'd2) ? 14'd1 : 14'd0);
		ok1 = job.ok && yf >= 14'd1601 && job.day >= 7'd1 &&
			job.hour <= 7'd23 && job.minute <= 7'd59 && job.second <= 7'd59 &&
			job.month >= 4'd1 && job.month <= 4'd12;
		// days before the month, with the year starting in march
		case (job.month)
			4'd3:  mstart = 9'd0;
			4'd4:  mstart = 9'd31;
			4'd5:  mstart = 9'd61;
			4'd6:  mstart = 9'd92;
			4'd7:  mstart = 9'd122;
			4'd8:  mstart = 9'd153;
			4'd9:  mstart = 9'd184;
			4'd10: mstart = 9'd214;
			4'd11: mstart = 9'd245;
			4'd12: mstart = 9'd275;
			4'd1:  mstart = 9'd306;
			4'd2:  mstart = 9'd337;
			default: mstart = 9'd0;
		endcase
		// hundreds by reciprocal multiplication, exact for four-digit years
		yf_mul = 27'(yf) * 27'd5243;
		y_mul  = 27'(y) * 27'd5243;
	end

	// stage 2: leap year, month length, day of era
	logic        ok_s2;
	logic [4:0]  era_s2;
	logic [17:0] doe_s2;
	logic [16:0] tod_s2;
	logic [62:0] now_s2;
	logic        leap, ok2;
	logic [4:0]  dim;
	logic [4:0]  era;
	logic [8:0]  yoe;
	logic [14:0] yoe_mul;
	logic [17:0] doe;

	always_comb begin
		// a century is a leap year only when its hundreds divide by four
		leap = (yf_s1[1:0] == 2'b00) &&
			((yf_s1 != 14'(yfh_s1) * 14'd100) || (yfh_s1[1:0] == 2'b00));
		case (mon_s1)
			4'd2: dim = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: dim = 5'd30;
			default: dim = 5'd31;
		endcase
		ok2 = ok_s1 && day_s1 <= {2'b00, dim};
		era = yh_s1[6:2];
		yoe = 9'(y_s1 - 14'(era) * 14'd400);
		yoe_mul = 15'(yoe) * 15'd41;
		doe = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(yoe_mul[14:12]) + 18'(doy_s1);
	end

	// stage 3: seconds
	logic        ok_s3;
	logic [38:0] stamp_s3;
	logic [62:0] now_s3;
	logic [22:0] days;
	assign days = 23'(era_s2) * 23'd146097 + 23'(doe_s2) - 23'd719468;

	assign adv_o = !v_q || pop;
	assign adv3  = !v_s3 || adv_o;
	assign adv2  = !v_s2 || adv3;
	assign adv1  = !v_s1 || adv2;
	assign job_pop = adv1 && !job_empty;
	assign empty = !v_q;

	// valid flags of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_q <= 1'b0;
		end else begin
			if (adv1) v_s1 <= !job_empty;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv_o) v_q <= v_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv1) begin
			ok_s1  <= ok1;
			yf_s1  <= yf;
			y_s1   <= y;
			yfh_s1 <= yf_mul[25:19];
			yh_s1  <= y_mul[25:19];
			mon_s1 <= job.month;
			day_s1 <= job.day;
			doy_s1 <= mstart + 9'(job.day) - 9'd1;
			tod_s1 <= 17'(job.hour) * 17'd3600 + 17'(job.minute) * 17'd60 +
				17'(job.second);
			now_s1 <= job.now;
		end
		if (adv2) begin
			ok_s2  <= ok2;
			era_s2 <= era;
			doe_s2 <= doe;
			tod_s2 <= tod_s1;
			now_s2 <= now_s1;
		end
		if (adv3) begin
			ok_s3    <= ok_s2;
			stamp_s3 <= {{16{days[22]}}, days} * 39'd86400 + 39'(tod_s2);
			now_s3   <= now_s2;
		end
		if (adv_o) begin
			result.date_valid <= ok_s3;
			if (!ok_s3) result.expiry_seconds <= '0;
			else if (stamp_s3[38] || {24'd0, stamp_s3} <= now_s3)
				result.expiry_seconds <= 38'd1;
			else result.expiry_seconds <= stamp_s3[37:0];
		end
	end

endmodule

[src/cookie_date_parser_core.sv]
// top level of the cookie date parser
// Takes one word per cycle while full is low (command 0: a character, 1: end of
// value with the current time). Character words give no result; each end word
// gives one result through a three-stage arithmetic path and an output register.
// Front and back are parted by a small queue (QueueDepth entries), so input
// keeps flowing while results wait to be popped; full rises only when the queue
// and back pipeline are all occupied.
module cookie_date_parser_core #(
	parameter int QueueDepth = cdp_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  cdp_pkg::in_word_t  in_word,
	output logic               empty,
	input  logic               pop,
	output cdp_pkg::out_word_t out_word
);
	import cdp_pkg::*;

	logic      job_valid, q_full, q_empty, q_pop;
	date_job_t job_w, job_r;

	assign full = q_full;

	cdp_front u_front (
		.clk, .arst_n, .valid(push && !q_full), .word(in_word),
		.job_valid, .job(job_w)
	);

	cdp_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .push(job_valid), .wdata(job_w), .full(q_full),
		.empty(q_empty), .pop(q_pop), .rdata(job_r)
	);

	cdp_back u_back (
		.clk, .arst_n, .job_empty(q_empty), .job(job_r), .job_pop(q_pop),
		.empty, .pop, .result(out_word)
	);

endmodule

[src/cdp_checker.sv]
// port-level checks of the cookie date parser, bound to the top level
module cdp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input cdp_pkg::in_word_t  in_word,
	input logic               empty,
	input logic               pop,
	input cdp_pkg::out_word_t out_word
);
	// an invalid result carries zero seconds
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_word.date_valid) |-> out_word.expiry_seconds == '0)
		else $error("invalid word with nonzero seconds");

	// a valid result is never zero
	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_word.date_valid) |-> out_word.expiry_seconds != '0)
		else $error("valid word with zero seconds");

	// a waiting result holds while not popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_word)))
		else $error("result changed while stalled");

	// a character word alone cannot make a result appear
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !full && $past(empty) && $past(empty, 2) && $past(empty, 3) &&
		 $past(empty, 4) && $past(!push || in_word.command == 1'b0, 1) &&
		 $past(!push || in_word.command == 1'b0, 2) &&
		 $past(!push || in_word.command == 1'b0, 3) &&
		 $past(!push || in_word.command == 1'b0, 4) &&
		 $past(!push || in_word.command == 1'b0, 5) &&
		 $past(!push || in_word.command == 1'b0, 6)) |=> empty)
		else $error("result without an end word");
endmodule

bind cookie_date_parser_core cdp_checker u_cdp_checker (.*);

[sim/tb_top.sv]
// self-checking testbench for the cookie date parser core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cdp_pkg::*;

	localparam int StallLimit = 20000;
	localparam int HoldCycles = 300;
	localparam int DrainCycles = 20;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_word_t in_word;
	logic empty;
	logic pop;
	out_word_t out_word;

	cookie_date_parser_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_word(in_word),
		.empty(empty),
		.pop(pop),
		.out_word(out_word)
	);

	// parser state mirrored at the block's widths
	logic [2:0]  tok_len;
	logic        tok_digits;
	logic [13:0] tok_num;
	logic [23:0] tok_prefix;
	logic [1:0]  scan_colons;
	logic [1:0]  scan_digits;
	logic        scan_bad;
	logic [6:0]  tok_clock [3];
	logic [3:0]  found;
	logic [6:0]  got_clock [3];
	logic [6:0]  got_day;
	logic [3:0]  got_month;
	logic [13:0] got_year;

	out_word_t expected_dates[$];
	int errors;
	int mismatches;
	int words_sent;
	int dates_checked;
	int valid_dates;
	int idle_cycles;
	bit idle_on;
	bit hold_req;

	const string MonthNames = "janfebmaraprmayjunjulaugsepoctnovdec";
	const logic [7:0] Colon = 8'h3a;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// token store cleared after a delimiter
	function automatic void clear_token();
		tok_len = '0;
		tok_digits = 1'b1;
		tok_num = '0;
		tok_prefix = '0;
		scan_colons = '0;
		scan_digits = '0;
		scan_bad = 1'b0;
		for (int i = 0; i < 3; i++) tok_clock[i] = '0;
	endfunction

	function automatic void clear_value();
		clear_token();
		found = '0;
		for (int i = 0; i < 3; i++) got_clock[i] = '0;
		got_day = '0;
		got_month = '0;
		got_year = '0;
	endfunction

	function automatic bit delimiter(logic [7:0] c);
		return c == 8'h09 || (c >= 8'h20 && c <= 8'h2f) || (c >= 8'h3b && c <= 8'h40) ||
			(c >= 8'h5b && c <= 8'h60) || (c >= 8'h7b && c <= 8'h7e);
	endfunction

	// one non-delimiter byte into the current token
	function automatic void add_char(logic [7:0] c);
		bit digit;
		logic [7:0] d;
		logic [7:0] lc;
		digit = c >= "0" && c <= "9";
		d = c - "0";
		if (tok_len < 3) begin
			lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
			tok_prefix = tok_prefix | (24'(lc) << (16 - 8 * tok_len));
		end
		if (digit) begin
			if (tok_digits && tok_len < 4) tok_num = 14'(tok_num * 10 + d);
			if (scan_digits >= 2) begin
				scan_bad = 1'b1;
			end else begin
				scan_digits++;
				if (scan_colons <= 2)
					tok_clock[scan_colons] = 7'(tok_clock[scan_colons] * 10 + d);
			end
		end else begin
			tok_digits = 1'b0;
			if (c == Colon) begin
				if (scan_digits == 0 || scan_colons >= 2) scan_bad = 1'b1;
				if (scan_colons < 3) scan_colons++;
				scan_digits = '0;
			end else begin
				scan_bad = 1'b1;
			end
		end
		if (tok_len < 5) tok_len++;
	endfunction

	function automatic logic [3:0] month_number();
		logic [23:0] p;
		if (tok_len < 3) return 4'd0;
		for (int m = 0; m < 12; m++) begin
			p = {MonthNames[3 * m], MonthNames[3 * m + 1], MonthNames[3 * m + 2]};
			if (p == tok_prefix) return 4'(m + 1);
		end
		return 4'd0;
	endfunction

	// classify a finished token: time, day, month, year in that order
	function automatic void close_token();
		logic [3:0] m;
		if (tok_len == 0) return;
		m = month_number();
		if (!found[0] && !scan_bad && scan_colons == 2 && scan_digits >= 1) begin
			for (int i = 0; i < 3; i++) got_clock[i] = tok_clock[i];
			found[0] = 1'b1;
		end else if (!found[1] && tok_digits && tok_len <= 2) begin
			got_day = tok_num[6:0];
			found[1] = 1'b1;
		end else if (!found[2] && m != 0) begin
			got_month = m;
			found[2] = 1'b1;
		end else if (!found[3] && tok_digits && tok_len >= 2 && tok_len <= 4) begin
			got_year = tok_num;
			found[3] = 1'b1;
		end
	endfunction

	function automatic longint days_from_epoch(longint y0, longint m, longint d);
		longint y, era, yoe, mp, doy, doe;
		y = y0 - (m <= 2 ? 1 : 0);
		era = y / 400;
		yoe = y - era * 400;
		mp = m > 2 ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	// expected result of one accepted word, if it makes one
	function automatic bit predict_date(in_word_t w, output out_word_t r);
		longint yr, dim, stamp;
		bit ok, leap;
		int lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		r = '0;
		if (!w.command) begin
			if (delimiter(w.char_byte)) begin
				close_token();
				clear_token();
			end else begin
				add_char(w.char_byte);
			end
			return 1'b0;
		end
		close_token();
		ok = found == 4'hf;
		yr = got_year;
		if (yr >= 70 && yr <= 99) yr += 1900;
		else if (yr <= 69) yr += 2000;
		if (ok) begin
			leap = (yr % 4 == 0) && (yr % 100 != 0 || yr % 400 == 0);
			dim = (got_month == 2 && leap) ? 29 : lengths[got_month - 1];
			if (yr < 1601 || got_day < 1 || got_day > dim || got_clock[0] > 23 ||
				got_clock[1] > 59 || got_clock[2] > 59) ok = 1'b0;
		end
		r.date_valid = ok;
		if (ok) begin
			stamp = days_from_epoch(yr, got_month, got_day) * 86400 +
				longint'(got_clock[0]) * 3600 + longint'(got_clock[1]) * 60 +
				longint'(got_clock[2]);
			r.expiry_seconds = (stamp <= longint'({1'b0, w.now_seconds})) ? 38'd1 : stamp[37:0];
		end
		clear_value();
		return 1'b1;
	endfunction

	// send one word, with an optional random gap first; push stays high after
	task automatic send_word(bit cmd, logic [7:0] c, logic [62:0] now);
		in_word_t w;
		out_word_t r;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		w.command = cmd;
		w.char_byte = c;
		w.now_seconds = now;
		push <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (full);
		words_sent++;
		if (predict_date(w, r)) expected_dates.insert(expected_dates.size(), r);
	endtask

	function automatic logic [62:0] rand_now();
		case ($urandom_range(0, 3))
			0: return 63'($urandom_range(0, 2000));
			1: return 63'({$urandom, $urandom});
			2: return 63'({$urandom_range(0, 63), $urandom});
			default: return 63'h7fff_ffff_ffff_ffff;
		endcase
	endfunction

	// characters of a value, then the end word
	task automatic send_value(logic [7:0] text[$], logic [62:0] now);
		foreach (text[i]) send_word(1'b0, text[i], 63'({$urandom, $urandom}));
		send_word(1'b1, 8'($urandom), now);
	endtask

	function automatic void put_str(ref logic [7:0] q[$], input string s);
		for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
	endfunction

	function automatic void put_num(ref logic [7:0] q[$], input int v, input int digits);
		string s;
		s.itoa(v);
		while (s.len() < digits) s = {"0", s};
		put_str(q, s);
	endfunction

	function automatic logic [7:0] rand_delim();
		case ($urandom_range(0, 4))
			0: return 8'h09;
			1: return 8'($urandom_range(8'h20, 8'h2f));
			2: return 8'($urandom_range(8'h3b, 8'h40));
			3: return 8'($urandom_range(8'h5b, 8'h60));
			default: return 8'($urandom_range(8'h7b, 8'h7e));
		endcase
	endfunction

	// a mostly well-formed date with parts shuffled and varied
	function automatic void make_date(ref logic [7:0] q[$]);
		string parts[$];
		string s, t;
		int m, k;
		// time
		s = "";
		for (int i = 0; i < 3; i++) begin
			t.itoa($urandom_range(0, 9) == 0 ? $urandom_range(0, 99) :
				$urandom_range(0, i == 0 ? 23 : 59));
			if (t.len() == 1 && $urandom_range(0, 1)) t = {"0", t};
			s = {s, t, i < 2 ? ":" : ""};
		end
		parts.insert(parts.size(), s);
		// day
		t.itoa($urandom_range(0, 7) == 0 ? $urandom_range(0, 99) : $urandom_range(1, 31));
		if ($urandom_range(0, 15) == 0) t = {t, "x"};
		parts.insert(parts.size(), t);
		// month, random case and sometimes the long form
		m = $urandom_range(0, 11);
		s = MonthNames.substr(3 * m, 3 * m + 2);
		if ($urandom_range(0, 3) == 0) s = {s, "ember"};
		for (int i = 0; i < s.len(); i++)
			if ($urandom_range(0, 1)) s[i] = s[i] - 8'h20;
		parts.insert(parts.size(), s);
		// year: two digits, four digits, or anything
		case ($urandom_range(0, 4))
			0: t.itoa($urandom_range(0, 99));
			1: t.itoa($urandom_range(1500, 1700));
			2: t.itoa($urandom_range(0, 9999));
			default: t.itoa($urandom_range(1970, 2100));
		endcase
		if (t.len() == 1) t = {"0", t};
		parts.insert(parts.size(), t);
		if ($urandom_range(0, 1)) parts.push_front("Wed");
		if ($urandom_range(0, 3) == 0) parts.insert(parts.size(), "GMT");
		if ($urandom_range(0, 2) == 0) parts.shuffle();
		if ($urandom_range(0, 9) == 0) parts.delete($urandom_range(0, parts.size() - 1));
		foreach (parts[i]) begin
			k = $urandom_range(1, 2);
			put_str(q, parts[i]);
			if (i < parts.size() - 1 || $urandom_range(0, 1))
				repeat (k) q.insert(q.size(), rand_delim());
		end
	endfunction

	task automatic random_value();
		logic [7:0] q[$];
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(0, 20)) q.insert(q.size(), 8'($urandom));
		end else begin
			make_date(q);
			if ($urandom_range(0, 9) == 0) q.insert($urandom_range(0, q.size()), 8'($urandom));
		end
		send_value(q, rand_now());
	endtask

	// corner values: extremes, leap days, year mapping, pending token
	task automatic test_directed();
		logic [7:0] q[$];
		put_str(q, "23:59:59 31 DEC 9999");
		send_value(q, 63'd0);
		q = {};
		send_value(q, 63'h7fff_ffff_ffff_ffff);
		put_str(q, "0:0:0 29 feb 00");
		send_value(q, 63'd0);
		q = {};
		put_str(q, "1:2:3 29 Feb 1900");
		send_value(q, 63'd0);
		q = {};
		put_str(q, "24:00:00 1 jan 1601");
		send_value(q, 63'd0);
		q = {};
		put_str(q, "1:1:1 1 Septembre 1601");
		send_value(q, 63'd5);
		q = {};
		put_str(q, "9:9:9 6x 7 jan 70");
		q.insert(q.size(), 8'hff);
		send_value(q, 63'd0);
		q = {};
		put_str(q, "1 2:3:4 mar 69");
		send_value(q, 63'h7fff_ffff_ffff_ffff);
	endtask

	task automatic test_random();
		int target;
		target = words_sent + 300;
		while (words_sent < target)
			random_value();
	endtask

	// receiver holds off while values keep coming, so the input backs up
	task automatic test_backpressure();
		hold_req = 1'b1;
		while (hold_req) random_value();
	endtask

	task automatic test_steady();
		idle_on = 1'b0;
		repeat (10) random_value();
		push <= 1'b0;
	endtask

	// result side: random stalls, long hold on request
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each popped word with the oldest expected date
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && pop && !empty) begin
			if (expected_dates.size() == 0) begin
				errors++;
				$display("unexpected word %0b %0d", out_word.date_valid, out_word.expiry_seconds);
			end else begin
				want = expected_dates.pop_front();
				dates_checked++;
				if (want.date_valid) valid_dates++;
				if (out_word !== want) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected valid %0b expiry %0d, got valid %0b expiry %0d",
							want.date_valid, want.expiry_seconds,
							out_word.date_valid, out_word.expiry_seconds);
				end
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_word = '0;
		errors = 0;
		mismatches = 0;
		words_sent = 0;
		dates_checked = 0;
		valid_dates = 0;
		idle_cycles = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		clear_value();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_random();
		test_steady();
		while (expected_dates.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("sent %0d words; checked %0d results, %0d of them valid dates",
			words_sent, dates_checked, valid_dates);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d errors", errors);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
